>>> rtl/core/isb_pkg.sv
// ----------------------------------------------------------------------------
// isb_pkg
// shared constants, codes and types of the indexed stack buffer
// ----------------------------------------------------------------------------
package isb_pkg;

  localparam int DEPTH      = 64;
  localparam int WORD_WIDTH = 32;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  localparam logic [2:0] OP_PUSH   = 3'd0;
  localparam logic [2:0] OP_POP    = 3'd1;
  localparam logic [2:0] OP_GET    = 3'd2;
  localparam logic [2:0] OP_SET    = 3'd3;
  localparam logic [2:0] OP_REMOVE = 3'd4;
  localparam logic [2:0] OP_CLEAR  = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;
  localparam logic [1:0] STAT_RANGE = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SH_RD,
    S_SH_WR,
    S_RESP
  } isb_state_t;

  typedef struct packed {
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [WORD_WIDTH-1:0] wr_data;
    logic                  rd_en;
    logic [ADDR_W-1:0]     rd_addr;
  } isb_mem_req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         count;
    logic               empty_flag;
  } isb_result_t;

  function automatic logic [WORD_WIDTH-1:0] to_word(input logic signed [31:0] v);
    return WORD_WIDTH'(v);
  endfunction

  function automatic logic signed [31:0] from_word(input logic [WORD_WIDTH-1:0] w);
    logic signed [WORD_WIDTH-1:0] s;
    s = w;
    return 32'(s);
  endfunction

endpackage

>>> rtl/core/isb_mem.sv
// ----------------------------------------------------------------------------
// isb_mem
// element store: one write and one registered read port
// ----------------------------------------------------------------------------
module isb_mem (
  input  logic                             clk,
  input  isb_pkg::isb_mem_req_t            req,
  output logic [isb_pkg::WORD_WIDTH-1:0]   rd_data
);
  import isb_pkg::*;

  logic [WORD_WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

>>> rtl/core/isb_seq.sv
// ----------------------------------------------------------------------------
// isb_seq
// command sequencer: fill count, bounds checks and the remove shift loop
// ----------------------------------------------------------------------------
module isb_seq (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     in_opcode,
  input  logic [5:0]                     in_index,
  input  logic signed [31:0]             in_value,
  input  logic [6:0]                     cap_limit,
  input  logic                           out_free,
  output isb_pkg::isb_mem_req_t          mem_req,
  input  logic [isb_pkg::WORD_WIDTH-1:0] rd_data,
  output logic                           res_valid,
  output isb_pkg::isb_result_t           res
);
  import isb_pkg::*;

  isb_state_t        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CMP_W-1:0]  ptr_r, ptr_nxt;
  logic [1:0]        status_r, status_nxt;
  logic              rdsel_r, rdsel_nxt;

  logic              accept;
  logic [CMP_W-1:0]  idx_x, cnt_x, cfg_x, cap_x, ptr_dec, ptr_inc, idx_inc, cnt_dec;
  logic              idx_bad;
  logic [CNT_W-1:0]  res_count;

  assign accept  = in_valid && !in_stall;
  assign in_stall = !((state_r == S_IDLE) && out_free);

  assign idx_x   = CMP_W'(in_index);
  assign cnt_x   = CMP_W'(count_r);
  assign cfg_x   = CMP_W'(cap_limit);
  assign cap_x   = (cfg_x < DEPTH_C) ? cfg_x : DEPTH_C;
  assign idx_bad = (idx_x >= cnt_x) || (idx_x >= DEPTH_C);
  assign ptr_dec = ptr_r - CMP_W'(1);
  assign ptr_inc = ptr_r + CMP_W'(1);
  assign idx_inc = idx_x + CMP_W'(1);
  assign cnt_dec = cnt_x - CMP_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    status_r <= status_nxt;
    rdsel_r  <= rdsel_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    status_nxt = status_r;
    rdsel_nxt  = rdsel_r;
    mem_req    = '0;
    res_valid  = 1'b0;
    res_count  = count_r;
    res.status     = status_r;
    res.read_value = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          status_nxt = STAT_OK;
          rdsel_nxt  = 1'b0;
          res_valid  = 1'b1;
          res.status = STAT_OK;
          unique case (in_opcode)
            OP_PUSH: begin
              if (cnt_x >= cap_x) begin
                res.status = STAT_FULL;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = count_r[ADDR_W-1:0];
                mem_req.wr_data = to_word(in_value);
                count_nxt       = count_r + CNT_W'(1);
              end
            end
            OP_POP: begin
              if (count_r == '0) begin
                res.status = STAT_EMPTY;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = cnt_dec[ADDR_W-1:0];
                count_nxt       = count_r - CNT_W'(1);
                rdsel_nxt       = 1'b1;
                res_valid       = 1'b0;
                state_nxt       = S_RESP;
              end
            end
            OP_GET: begin
              if (idx_bad) begin
                res.status = STAT_RANGE;
              end else begin
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = idx_x[ADDR_W-1:0];
                rdsel_nxt       = 1'b1;
                res_valid       = 1'b0;
                state_nxt       = S_RESP;
              end
            end
            OP_SET: begin
              if (idx_bad) begin
                res.status = STAT_RANGE;
              end else begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = idx_x[ADDR_W-1:0];
                mem_req.wr_data = to_word(in_value);
              end
            end
            OP_REMOVE: begin
              if (idx_bad) begin
                res.status = STAT_RANGE;
              end else begin
                count_nxt = count_r - CNT_W'(1);
                ptr_nxt   = idx_inc;
                if (idx_inc < cnt_x) begin
                  res_valid = 1'b0;
                  state_nxt = S_SH_RD;
                end
              end
            end
            OP_CLEAR: begin
              count_nxt = '0;
            end
            default: begin
            end
          endcase
          res_count = count_nxt;
        end
      end
      S_SH_RD: begin
        mem_req.rd_en   = 1'b1;
        mem_req.rd_addr = ptr_r[ADDR_W-1:0];
        state_nxt       = S_SH_WR;
      end
      S_SH_WR: begin
        mem_req.wr_en   = 1'b1;
        mem_req.wr_addr = ptr_dec[ADDR_W-1:0];
        mem_req.wr_data = rd_data;
        ptr_nxt         = ptr_inc;
        state_nxt       = (ptr_inc <= cnt_x) ? S_SH_RD : S_RESP;
      end
      S_RESP: begin
        if (out_free) begin
          res_valid = 1'b1;
          if (rdsel_r) begin
            res.read_value = from_word(rd_data);
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    res.count      = 7'(res_count);
    res.empty_flag = (res_count == '0);
  end

  // fill count never passes the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(count_r) <= DEPTH_C)
    else $error("fill count above depth");

  // a result is only offered when the output side has room
  a_res_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> out_free)
    else $error("result issued without output room");

  // shift write pointer stays inside the live region
  a_shift_ptr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SH_WR) |-> (ptr_r != '0) && (ptr_r <= cnt_x))
    else $error("shift pointer out of range");

  // a successful push grows the count by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_opcode == OP_PUSH) && (cnt_x < cap_x))
      |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("push did not grow count");

endmodule

>>> rtl/core/indexed_stack_buffer.sv
// ----------------------------------------------------------------------------
// indexed_stack_buffer
// fixed store of signed words with a fill count and indexed access
//
//   channel  direction  handshake          payload
//   in_      input      in_valid/in_stall  in_opcode, in_index, in_value
//   out_     output     out_valid/out_stall out_status, out_read_value,
//                                           out_count, out_empty
//   cfg_     input      cfg_valid/cfg_ready cfg_data (capacity limit)
//
// push, set, clear, refused commands and remove of the last element answer from
// the idle state; pop and get wait in S_RESP on the registered store read
// other removes step through S_SH_RD and S_SH_WR for count - 1 - index elements, count
// taken before the remove: one read and one write of the store per element moved down
// rst_n clears the fill count and sets the capacity to 64; the store is not cleared
// out_stall holds the result register; in_stall rises while a command is in
// work or the result register cannot be freed
// ----------------------------------------------------------------------------
module indexed_stack_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [2:0]         in_opcode,
  input  logic [5:0]         in_index,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_read_value,
  output logic [6:0]         out_count,
  output logic               out_empty,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [6:0]         cfg_data
);
  import isb_pkg::*;

  logic [6:0]            cap_r, cap_nxt;
  logic                  out_valid_r, out_valid_nxt;
  isb_result_t           out_r;
  logic                  out_free;
  isb_mem_req_t          mem_req;
  logic [WORD_WIDTH-1:0] rd_data;
  logic                  res_valid;
  isb_result_t           res;

  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid_r || !out_stall;

  assign cap_nxt       = (cfg_valid && cfg_ready) ? cfg_data : cap_r;
  assign out_valid_nxt = res_valid || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= 7'd64;
      out_valid_r <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  isb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_opcode (in_opcode),
    .in_index  (in_index),
    .in_value  (in_value),
    .cap_limit (cap_r),
    .out_free  (out_free),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res       (res)
  );

  isb_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  assign out_valid      = out_valid_r;
  assign out_status     = out_r.status;
  assign out_read_value = out_r.read_value;
  assign out_count      = out_r.count;
  assign out_empty      = out_r.empty_flag;

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the indexed stack buffer: a shadow copy of the store
// and fill count predicts status, read word, count and empty flag for every
// accepted command, under random gaps and stalls on both channels and over a
// range of capacity settings
// ----------------------------------------------------------------------------
module tb_top;
  import isb_pkg::*;

  localparam logic [2:0] OP_SPARE6 = 3'd6;
  localparam logic [2:0] OP_SPARE7 = 3'd7;

  typedef logic [WORD_WIDTH-1:0] word_t;

  class vector_tracker;
    word_t       slots [DEPTH];
    int unsigned fill;
    logic [6:0]  cap_reg;
    isb_result_t awaited [$];
    int unsigned mismatches;
    int unsigned commands;
    int unsigned status_tally [4];

    function new();
      foreach (slots[i]) slots[i] = '0;
      fill = 0;
      cap_reg = 7'd64;
      mismatches = 0;
      commands = 0;
      foreach (status_tally[i]) status_tally[i] = 0;
    endfunction

    function void apply_command(logic [2:0] op, logic [5:0] idx, logic signed [31:0] val);
      isb_result_t r;
      int unsigned lim;
      int unsigned i;
      lim = (cap_reg < DEPTH) ? cap_reg : DEPTH;
      r = '0;
      r.status = STAT_OK;
      case (op)
        OP_PUSH: begin
          if (fill >= lim) r.status = STAT_FULL;
          else begin
            slots[fill] = WORD_WIDTH'(val);
            fill++;
          end
        end
        OP_POP: begin
          if (fill == 0) r.status = STAT_EMPTY;
          else begin
            fill--;
            r.read_value = $signed(slots[fill]);
          end
        end
        OP_GET: begin
          if (idx >= fill) r.status = STAT_RANGE;
          else r.read_value = $signed(slots[idx]);
        end
        OP_SET: begin
          if (idx >= fill) r.status = STAT_RANGE;
          else slots[idx] = WORD_WIDTH'(val);
        end
        OP_REMOVE: begin
          if (idx >= fill) r.status = STAT_RANGE;
          else begin
            for (i = idx; i + 1 < fill; i++) slots[i] = slots[i + 1];
            fill--;
          end
        end
        OP_CLEAR: fill = 0;
        default: ;
      endcase
      r.count = 7'(fill);
      r.empty_flag = (fill == 0);
      commands++;
      status_tally[r.status]++;
      awaited = {awaited, r};
    endfunction

    function void check_result(logic [1:0] status, logic signed [31:0] rd,
                               logic [6:0] count, logic empty_flag);
      isb_result_t exp;
      if (awaited.size() == 0) begin
        $error("out word with no command pending: status %0d count %0d", status, count);
        mismatches++;
        return;
      end
      exp = awaited.pop_front();
      if (status !== exp.status) begin
        $error("status: expected %0d, actual %0d", exp.status, status);
        mismatches++;
      end
      if (rd !== exp.read_value) begin
        $error("read_value: expected %0d, actual %0d", exp.read_value, rd);
        mismatches++;
      end
      if (count !== exp.count) begin
        $error("count: expected %0d, actual %0d", exp.count, count);
        mismatches++;
      end
      if (empty_flag !== exp.empty_flag) begin
        $error("empty flag: expected %0d, actual %0d", exp.empty_flag, empty_flag);
        mismatches++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [2:0]         in_opcode = OP_PUSH;
  logic [5:0]         in_index = '0;
  logic signed [31:0] in_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [1:0]         out_status;
  logic signed [31:0] out_read_value;
  logic [6:0]         out_count;
  logic               out_empty;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [6:0]         cfg_data = '0;

  vector_tracker trk = new();
  bit            calm = 1'b0;
  int unsigned   settings = 0;

  indexed_stack_buffer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_index       (in_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_status     (out_status),
    .out_read_value (out_read_value),
    .out_count      (out_count),
    .out_empty      (out_empty),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        trk.check_result(out_status, out_read_value, out_count, out_empty);
      if (in_valid && !in_stall) trk.apply_command(in_opcode, in_index, in_value);
    end
  end

  initial begin
    int stalls;
    forever begin
      stalls = calm ? 0 : $urandom_range(0, 6);
      if (stalls > 0) begin
        out_stall <= 1'b1;
        repeat (stalls) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
    end
  end

  task automatic issue(input logic [2:0] op, input logic [5:0] idx,
                       input logic signed [31:0] val);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_opcode <= op;
    in_index  <= idx;
    in_value  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off until every word is back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (trk.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [6:0] cap);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    trk.cap_reg = cap;
    settings++;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_command(input bit heavy);
    logic [2:0]  op;
    logic [5:0]  idx;
    int unsigned r;
    int unsigned fill;
    fill = trk.fill;
    if ($urandom_range(0, 99) < (heavy ? 65 : 25)) op = OP_PUSH;
    else begin
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_POP;
      else if (r < 46) op = OP_GET;
      else if (r < 72) op = OP_SET;
      else if (r < 97) op = OP_REMOVE;
      else if (r < 98) op = heavy ? OP_GET : OP_CLEAR;
      else if (r < 99) op = OP_SPARE6;
      else op = OP_SPARE7;
    end
    r = $urandom_range(0, 7);
    if (r < 6 && fill > 0) idx = 6'($urandom_range(0, fill - 1));
    else if (r == 6 && fill < DEPTH) idx = 6'(fill);
    else idx = 6'($urandom_range(0, 63));
    issue(op, idx, pick_value());
  endtask

  initial begin
    logic [6:0] caps [10];
    caps = '{7'd127, 7'd64, 7'd1, 7'd0, 7'd100, 7'd33, 7'($urandom_range(1, 64)),
             7'd2, 7'd64, 7'($urandom_range(0, 127))};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty store and bad indexes, then pushes, sets, gets, removes, spare opcodes, pops and clears
    issue(OP_POP, 6'd0, 32'sd0);
    issue(OP_GET, 6'd0, 32'sd0);
    issue(OP_SET, 6'd0, 32'sd1);
    issue(OP_REMOVE, 6'd0, 32'sd0);
    issue(OP_PUSH, 6'd63, 32'sh7fffffff);
    issue(OP_PUSH, 6'd0, 32'sh80000000);
    issue(OP_PUSH, 6'd21, -32'sd1);
    issue(OP_PUSH, 6'd42, 32'sd0);
    issue(OP_GET, 6'd0, 32'sd0);
    issue(OP_GET, 6'd3, 32'sd0);
    issue(OP_GET, 6'd4, 32'sd0);
    issue(OP_SET, 6'd1, 32'sh55555555);
    issue(OP_GET, 6'd1, 32'sd0);
    issue(OP_REMOVE, 6'd0, 32'sd0);
    issue(OP_REMOVE, 6'd2, 32'sd0);
    issue(OP_GET, 6'd63, 32'sd0);
    issue(OP_SPARE6, 6'd0, 32'sd7);
    issue(OP_SPARE7, 6'd63, -32'sd1);
    issue(OP_POP, 6'd0, 32'sd0);
    issue(OP_POP, 6'd0, 32'sd0);
    issue(OP_POP, 6'd0, 32'sd0);
    issue(OP_CLEAR, 6'd0, 32'sd0);
    issue(OP_PUSH, 6'd0, 32'sh12345678);
    issue(OP_CLEAR, 6'd0, 32'sd0);
    drain();
    // tiny capacity, then capacity below count
    set_capacity(7'd1);
    issue(OP_PUSH, 6'd0, 32'sd11);
    issue(OP_PUSH, 6'd0, 32'sd12);
    drain();
    set_capacity(7'd0);
    issue(OP_PUSH, 6'd0, 32'sd13);
    issue(OP_GET, 6'd0, 32'sd0);
    drain();

    for (int p = 0; p < 10; p++) begin
      calm = (p % 3 == 1);
      set_capacity(caps[p]);
      repeat (188) random_command(p % 2 == 0);
      drain();
    end
    calm = 1'b0;

    repeat (140) @(posedge clk);
    $display("covered %0d commands over %0d capacity settings, capacity 0 to 127",
             trk.commands, settings);
    $display("status mix: ok %0d, full %0d, empty %0d, out of range %0d",
             trk.status_tally[STAT_OK], trk.status_tally[STAT_FULL],
             trk.status_tally[STAT_EMPTY], trk.status_tally[STAT_RANGE]);
    if (trk.mismatches == 0 && trk.awaited.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #12_000_000;
    $display("timeout with %0d words outstanding", trk.awaited.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/isb_pkg.sv
rtl/core/isb_mem.sv
rtl/core/isb_seq.sv
rtl/core/indexed_stack_buffer.sv
verif/tb_top.sv
